>>> design/lwfc_pkg.sv
// ----------------------------------------------------------------------------
// lwfc_pkg
// Shared types, constants and helper functions of the wake-up light fade
// controller: payload structs, command codes, FSM states, stage colors.
// ----------------------------------------------------------------------------
package lwfc_pkg;

  localparam int STAGE_COUNT_DEF   = 9;
  localparam int FRACTION_BITS_DEF = 16;

  localparam logic [7:0]  FRONT_MAX_WHITE  = 8'd200;
  localparam logic [7:0]  FRONT_MAX_RED    = 8'd170;
  localparam logic [31:0] FRONT_ON_MS      = 32'd10000;
  localparam logic [31:0] FRONT_FADE_MS    = 32'd5000;
  localparam logic [31:0] NIGHT_FADE_MS    = 32'd1000;
  localparam logic [31:0] FRONT_GRACE_MS   = 32'd3000;
  localparam logic [31:0] DISMISS_HOLD_MS  = 32'd500;
  localparam logic [31:0] DISMISS_FADE_MS  = 32'd1000;
  localparam logic [31:0] RAMP_INTERVAL_MS = 32'd10000;
  localparam logic [6:0]  FRONT_CUT_PCT    = 7'd40;
  localparam logic [6:0]  NIGHT_CUT_PCT    = 7'd30;

  localparam logic [31:0] NIGHT_AT_RST   = 32'd4294966296;
  localparam logic [15:0] LAST_FRONT_RST = 16'h0101;
  localparam logic [31:0] LAST_WAKE_RST  = 32'h0101_0101;

  localparam logic [2:0] CMD_UPDATE       = 3'd0;
  localparam logic [2:0] CMD_TRIGGER      = 3'd1;
  localparam logic [2:0] CMD_END_HOLD     = 3'd2;
  localparam logic [2:0] CMD_TOGGLE_NIGHT = 3'd3;
  localparam logic [2:0] CMD_DISMISS      = 3'd4;

  localparam logic [1:0] EDIT_NONE  = 2'd0;
  localparam logic [1:0] EDIT_FRONT = 2'd1;
  localparam logic [1:0] EDIT_WAKE  = 2'd2;
  localparam logic [1:0] EDIT_NIGHT = 2'd3;

  localparam logic [2:0] CFG_FRONT_PCT   = 3'd0;
  localparam logic [2:0] CFG_NIGHT_PCT   = 3'd1;
  localparam logic [2:0] CFG_WAKE_PCT    = 3'd2;
  localparam logic [2:0] CFG_WAKE_EN     = 3'd3;
  localparam logic [2:0] CFG_RAMP_MIN    = 3'd4;
  localparam logic [2:0] CFG_MANUAL_MODE = 3'd5;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] now_ms;
    logic        ringing;
    logic        keep_alive;
    logic [1:0]  edit_target;
    logic [6:0]  preview_pct;
    logic        alarm_pending;
    logic [13:0] minutes_until_alarm;
    logic [5:0]  now_sec;
  } in_item_t;

  typedef struct packed {
    logic [7:0] front_red;
    logic [7:0] front_white;
    logic [7:0] wake_red;
    logic [7:0] wake_green;
    logic [7:0] wake_blue;
    logic [7:0] wake_white;
    logic       front_changed;
    logic       wake_changed;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CMD, ST_KEEP, ST_FSEL, ST_FDIV, ST_FMUL, ST_FCOL, ST_WSEL,
    ST_WDIV, ST_DFADE, ST_NMUL, ST_RAMPF, ST_SPOS, ST_SINT, ST_DIM, ST_WOUT
  } state_t;

  typedef enum logic [2:0] {
    W_DIRECT, W_SUN, W_DISMISS, W_NIGHT, W_RAMP
  } wsel_t;

  typedef struct packed {
    logic load;
    logic apply_cmd;
    logic keep;
    logic fsel;
    logic frac_take;
    logic fmul;
    logic fcol;
    logic wsel;
    logic div_start;
    logic dfade;
    logic nmul;
    logic rampf;
    logic spos;
    logic sint;
    logic dim;
    logic wout;
  } lwfc_ctl_t;

  typedef struct packed {
    logic  f_need_div;
    wsel_t wsel;
    logic  div_busy;
    logic  div_done;
  } lwfc_sts_t;

  // floor(x/100) for x < 32768
  function automatic logic [8:0] div100(input logic [14:0] x);
    logic [27:0] t;
    t = 28'(x) * 28'd5243;
    return t[27:19];
  endfunction

  function automatic logic [7:0] pct_byte(input logic [6:0] p);
    logic [8:0] v;
    v = div100(15'(p) * 15'd255);
    return v[8] ? 8'd255 : v[7:0];
  endfunction

  function automatic logic [31:0] dim_color(input logic [31:0] c, input logic [7:0] r);
    logic [31:0] o;
    logic [15:0] t;
    o = '0;
    for (int k = 0; k < 4; k++) begin
      t = 16'(c[8*k +: 8]) * (16'(r) + 16'd1);
      o[8*k +: 8] = t[15:8];
    end
    return o;
  endfunction

  // {red, green, blue, white}
  function automatic logic [31:0] stage_color(input logic [3:0] i);
    logic [31:0] c;
    unique case (i)
      4'd0:    c = {8'd25,  8'd12,  8'd0,   8'd0};
      4'd1:    c = {8'd70,  8'd30,  8'd0,   8'd0};
      4'd2:    c = {8'd150, 8'd60,  8'd0,   8'd0};
      4'd3:    c = {8'd220, 8'd90,  8'd0,   8'd5};
      4'd4:    c = {8'd255, 8'd110, 8'd0,   8'd10};
      4'd5:    c = {8'd255, 8'd130, 8'd15,  8'd40};
      4'd6:    c = {8'd255, 8'd150, 8'd30,  8'd100};
      4'd7:    c = {8'd255, 8'd180, 8'd90,  8'd180};
      default: c = {8'd255, 8'd210, 8'd150, 8'd255};
    endcase
    return c;
  endfunction

endpackage

>>> design/lwfc_div.sv
// ----------------------------------------------------------------------------
// lwfc_div
// Restoring divider, one quotient bit per cycle. Quotient holds after done.
// ----------------------------------------------------------------------------
module lwfc_div #(
  parameter int NUM_W = 30,
  parameter int DEN_W = 14
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output logic             busy,
  output logic             done
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] den_r, rem_r, rem_nxt;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r;
  logic [DEN_W:0]   sh, diff;
  logic             ge;

  assign sh   = {rem_r, num_r[NUM_W-1]};
  assign diff = sh - {1'b0, den_r};
  assign ge   = sh >= {1'b0, den_r};

  always_comb begin
    rem_nxt = ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
    num_nxt = {num_r[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quo  = num_r;
  assign busy = busy_r;
  assign done = done_r;

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> rem_r < den_r)
    else $error("divider remainder not below divisor");

endmodule

>>> design/lwfc_dp.sv
// ----------------------------------------------------------------------------
// lwfc_dp
// Datapath: configuration and fade state, front and wake color arithmetic,
// ramp divider, output register.
// ----------------------------------------------------------------------------
module lwfc_dp
  import lwfc_pkg::*;
#(
  parameter int STAGE_COUNT   = STAGE_COUNT_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  lwfc_ctl_t  ctl,
  output lwfc_sts_t  sts,
  input  in_item_t   in_data,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int FB = FRACTION_BITS;
  localparam int NW = FB + 14;
  localparam logic [FB:0] ONE_Q = {1'b1, {FB{1'b0}}};
  localparam logic [4:0]  LAST_IDX = 5'(STAGE_COUNT - 1);

  // reciprocals for (x << FB) / 5000 and (x << FB) / 1000, exact for x below
  // the divisor
  localparam int RS_F = 26;
  localparam int RS_N = 20;
  localparam logic [63:0] RCP_F =
    ((64'd1 << (FB + RS_F)) + 64'(FRONT_FADE_MS) - 64'd1) / 64'(FRONT_FADE_MS);
  localparam logic [63:0] RCP_N =
    ((64'd1 << (FB + RS_N)) + 64'(NIGHT_FADE_MS) - 64'd1) / 64'(NIGHT_FADE_MS);

  // configuration
  logic [6:0] front_pct_r, night_pct_r, wake_pct_r;
  logic       wake_en_r, manual_mode_r;
  logic [7:0] ramp_min_r;

  // persistent state
  in_item_t    item_r;
  logic [31:0] hold_r, night_at_r, dis_start_r, dis_from_r;
  logic [31:0] last_wake_r, last_ramp_r, cached_r;
  logic [15:0] last_front_r;
  logic        manual_on_r, night_on_r;

  // work registers
  logic [6:0]      fpct_r;
  logic [FB:0]     frac_r, f_r, sf_r, rq_r;
  logic [FB+15:0]  prod_red_r, prod_wht_r;
  logic [15:0]     fc_r;
  logic            fch_r;
  logic [31:0]     wc_r, sun_r;
  logic [7:0]      dimr_r;
  logic [3:0]      idx_r;
  logic            src_dis_r, ramp_wr_r;
  out_item_t       out_r;

  // divider
  logic [NW-1:0] div_num, div_q;
  logic [13:0]   div_den;
  logic          div_busy, div_done;

  lwfc_div #(.NUM_W(NW), .DEN_W(14)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_q),
    .busy  (div_busy),
    .done  (div_done)
  );

  // front selection
  logic [31:0] f_d, f_fe;
  logic [6:0]  f_pct;
  logic [FB:0] f_frac;
  logic        f_need, f_clr;
  logic [FB+26:0] f_q_prod;
  logic [FB:0]    f_q;

  assign f_d      = hold_r - item_r.now_ms;
  assign f_fe     = item_r.now_ms - hold_r;
  assign f_q_prod = (FB+27)'(f_fe[12:0]) * (FB+27)'(RCP_F[FB+13:0]);
  assign f_q      = f_q_prod[FB+26:RS_F];

  always_comb begin
    f_pct  = front_pct_r;
    f_frac = ONE_Q;
    f_need = 1'b0;
    f_clr  = 1'b0;
    if (item_r.edit_target == EDIT_FRONT) begin
      f_pct = item_r.preview_pct;
    end else if (item_r.ringing || manual_on_r) begin
      f_frac = ONE_Q;
    end else if (hold_r == '0) begin
      f_frac = '0;
    end else if (f_d != '0 && !f_d[31]) begin
      f_frac = ONE_Q;
    end else if (front_pct_r < FRONT_CUT_PCT || f_fe >= FRONT_FADE_MS) begin
      f_frac = '0;
      f_clr  = 1'b1;
    end else begin
      f_need = 1'b1;
    end
  end

  // front color
  logic [14:0] k_red, k_wht;
  logic [8:0]  c_red, c_wht;
  logic [15:0] fc_nxt;

  assign k_red = 15'(FRONT_MAX_RED) * 15'(fpct_r);
  assign k_wht = 15'(FRONT_MAX_WHITE) * 15'(fpct_r);

  always_comb begin
    c_red  = div100(prod_red_r[FB+14:FB]);
    c_wht  = div100(prod_wht_r[FB+14:FB]);
    fc_nxt = {c_red[8] ? 8'd255 : c_red[7:0], c_wht[8] ? 8'd255 : c_wht[7:0]};
  end

  // wake selection
  logic [31:0] dis_el, ngt_el, ramp_el, de;
  logic [19:0] mins60;
  logic signed [20:0] left_s;
  logic [13:0] dur;
  logic [7:0]  ngt_tgt, wake_byte;
  wsel_t       w_code;
  logic [31:0] w_wc;
  logic [FB:0] w_f;
  logic [7:0]  w_dimr;
  logic        w_clr_dis, w_ramp_upd, w_cache_clr, w_ramp_wr;
  logic [9:0]  w_x;
  logic [FB+20:0] w_q_prod;
  logic [FB:0]    w_q;

  assign dis_el  = item_r.now_ms - dis_start_r;
  assign ngt_el  = item_r.now_ms - night_at_r;
  assign ramp_el = item_r.now_ms - last_ramp_r;
  assign de      = dis_el - DISMISS_HOLD_MS;
  assign mins60  = 20'(item_r.minutes_until_alarm) * 20'd60;
  assign left_s  = $signed({1'b0, mins60}) - $signed({15'b0, item_r.now_sec});
  assign dur     = 14'(ramp_min_r) * 14'd60;
  assign ngt_tgt = pct_byte(night_pct_r);
  assign wake_byte = pct_byte(wake_pct_r);

  always_comb begin
    w_code      = W_DIRECT;
    w_wc        = '0;
    w_f         = ONE_Q;
    w_dimr      = wake_byte;
    w_clr_dis   = 1'b0;
    w_ramp_upd  = 1'b0;
    w_cache_clr = 1'b0;
    w_ramp_wr   = 1'b0;
    w_x         = ngt_el[9:0];
    if (item_r.ringing && wake_en_r) begin
      w_code    = W_SUN;
      w_clr_dis = 1'b1;
    end else if (item_r.edit_target == EDIT_WAKE) begin
      w_code = W_SUN;
      w_dimr = pct_byte(item_r.preview_pct);
    end else if (item_r.edit_target == EDIT_NIGHT) begin
      w_wc = {24'b0, pct_byte(item_r.preview_pct)};
    end else if (dis_start_r != '0 && dis_el < DISMISS_HOLD_MS + DISMISS_FADE_MS) begin
      if (dis_el < DISMISS_HOLD_MS) begin
        w_wc = dis_from_r;
      end else begin
        w_code = W_DISMISS;
        w_x    = de[9:0];
      end
    end else if (night_on_r || ngt_el < NIGHT_FADE_MS) begin
      if (night_pct_r < NIGHT_CUT_PCT || ngt_el >= NIGHT_FADE_MS) begin
        w_wc = {24'b0, night_on_r ? ngt_tgt : 8'd0};
      end else begin
        w_code = W_NIGHT;
      end
    end else if (wake_en_r && item_r.alarm_pending && ramp_min_r != '0) begin
      if (ramp_el >= RAMP_INTERVAL_MS) begin
        w_ramp_upd = 1'b1;
        if (left_s <= $signed({7'b0, dur})) begin
          w_ramp_wr = 1'b1;
          if (left_s[20]) begin
            w_code = W_SUN;
          end else begin
            w_code = W_RAMP;
          end
        end else begin
          w_cache_clr = 1'b1;
        end
      end else begin
        w_wc = cached_r;
      end
    end
  end

  assign w_q_prod = (FB+21)'(w_x) * (FB+21)'(RCP_N[FB+10:0]);
  assign w_q      = w_q_prod[FB+20:RS_N];

  assign div_num = {left_s[13:0], {FB{1'b0}}};
  assign div_den = dur;

  // post-division arithmetic
  logic [FB:0]   q_inv, ramp_inv;
  logic [FB+8:0] dis_r_prod, ngt_prod;
  logic [FB+4:0] pos;
  logic [4:0]    idx_raw;
  logic [3:0]    idx_c;
  logic [FB+4:0] sf_full;
  logic [31:0]   a_col, b_col, sun_nxt, dim_src, dim_out;
  logic [7:0]    dch;
  logic [FB+8:0] ip;
  logic [8:0]    iv;

  assign q_inv      = ONE_Q - rq_r;
  assign ramp_inv   = ONE_Q - div_q[FB:0];
  assign dis_r_prod = (FB+9)'(8'd255) * (FB+9)'(q_inv);
  assign ngt_prod   = (FB+9)'(ngt_tgt) * (FB+9)'(night_on_r ? rq_r : q_inv);

  always_comb begin
    pos     = (FB+5)'(f_r) * (FB+5)'(LAST_IDX);
    idx_raw = pos[FB+4:FB];
    idx_c   = (idx_raw >= LAST_IDX) ? 4'(LAST_IDX - 5'd1) : idx_raw[3:0];
    sf_full = pos - {1'b0, idx_c, {FB{1'b0}}};
  end

  always_comb begin
    a_col   = stage_color(idx_r);
    b_col   = stage_color(idx_r + 4'd1);
    sun_nxt = '0;
    for (int k = 0; k < 4; k++) begin
      dch = b_col[8*k +: 8] - a_col[8*k +: 8];
      ip  = (FB+9)'(dch) * (FB+9)'(sf_r);
      iv  = {1'b0, a_col[8*k +: 8]} + ip[FB+8:FB];
      if (b_col[8*k +: 8] < a_col[8*k +: 8]) iv = {1'b0, a_col[8*k +: 8]};
      sun_nxt[8*k +: 8] = iv[8] ? 8'd255 : iv[7:0];
    end
  end

  assign dim_src = src_dis_r ? dis_from_r : sun_r;
  assign dim_out = dim_color(dim_src, dimr_r);

  // configuration and persistent state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_pct_r   <= 7'd50;
      night_pct_r   <= 7'd50;
      wake_pct_r    <= 7'd100;
      wake_en_r     <= 1'b1;
      ramp_min_r    <= 8'd30;
      manual_mode_r <= 1'b0;
      hold_r        <= '0;
      manual_on_r   <= 1'b0;
      night_on_r    <= 1'b0;
      night_at_r    <= NIGHT_AT_RST;
      dis_start_r   <= '0;
      dis_from_r    <= '0;
      last_front_r  <= LAST_FRONT_RST;
      last_wake_r   <= LAST_WAKE_RST;
      last_ramp_r   <= '0;
      cached_r      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FRONT_PCT:   front_pct_r   <= cfg_data[6:0];
          CFG_NIGHT_PCT:   night_pct_r   <= cfg_data[6:0];
          CFG_WAKE_PCT:    wake_pct_r    <= cfg_data[6:0];
          CFG_WAKE_EN:     wake_en_r     <= cfg_data[0];
          CFG_RAMP_MIN:    ramp_min_r    <= cfg_data;
          CFG_MANUAL_MODE: manual_mode_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (ctl.apply_cmd) begin
        unique case (item_r.cmd)
          CMD_TRIGGER: begin
            if (manual_mode_r) manual_on_r <= 1'b1;
            else hold_r <= item_r.now_ms + FRONT_ON_MS;
          end
          CMD_END_HOLD: begin
            if (manual_on_r) begin
              manual_on_r <= 1'b0;
              hold_r      <= item_r.now_ms;
            end
          end
          CMD_TOGGLE_NIGHT: begin
            night_on_r <= !night_on_r;
            night_at_r <= item_r.now_ms;
          end
          CMD_DISMISS: begin
            night_on_r  <= 1'b0;
            night_at_r  <= item_r.now_ms - NIGHT_FADE_MS;
            dis_from_r  <= last_wake_r;
            dis_start_r <= item_r.now_ms;
          end
          default: ;
        endcase
      end
      if (ctl.keep && item_r.keep_alive && hold_r != '0) begin
        hold_r <= item_r.now_ms + FRONT_GRACE_MS;
      end
      if (ctl.fsel && f_clr) hold_r <= '0;
      if (ctl.fcol) last_front_r <= fc_nxt;
      if (ctl.wsel) begin
        if (w_clr_dis)   dis_start_r <= '0;
        if (w_ramp_upd)  last_ramp_r <= item_r.now_ms;
        if (w_cache_clr) cached_r    <= '0;
      end
      if (ctl.dim && ramp_wr_r) cached_r <= dim_out;
      if (ctl.wout) last_wake_r <= wc_r;
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    if (ctl.load) item_r <= in_data;
    if (ctl.fsel) begin
      fpct_r <= f_pct;
      frac_r <= f_frac;
      rq_r   <= f_q;
    end
    if (ctl.frac_take) frac_r <= q_inv;
    if (ctl.fmul) begin
      prod_red_r <= (FB+16)'(k_red) * (FB+16)'(frac_r);
      prod_wht_r <= (FB+16)'(k_wht) * (FB+16)'(frac_r);
    end
    if (ctl.fcol) begin
      fc_r  <= fc_nxt;
      fch_r <= fc_nxt != last_front_r;
    end
    if (ctl.wsel) begin
      wc_r      <= w_wc;
      f_r       <= w_f;
      dimr_r    <= w_dimr;
      ramp_wr_r <= w_ramp_wr;
      src_dis_r <= 1'b0;
      rq_r      <= w_q;
    end
    if (ctl.dfade) begin
      dimr_r    <= dis_r_prod[FB+7:FB];
      src_dis_r <= 1'b1;
    end
    if (ctl.nmul)  wc_r <= {24'b0, ngt_prod[FB+7:FB]};
    if (ctl.rampf) f_r  <= ramp_inv;
    if (ctl.spos) begin
      idx_r <= idx_c;
      sf_r  <= sf_full[FB:0];
    end
    if (ctl.sint) sun_r <= sun_nxt;
    if (ctl.dim)  wc_r  <= dim_out;
    if (ctl.wout) begin
      out_r.front_red     <= fc_r[15:8];
      out_r.front_white   <= fc_r[7:0];
      out_r.wake_red      <= wc_r[31:24];
      out_r.wake_green    <= wc_r[23:16];
      out_r.wake_blue     <= wc_r[15:8];
      out_r.wake_white    <= wc_r[7:0];
      out_r.front_changed <= fch_r;
      out_r.wake_changed  <= wc_r != last_wake_r;
    end
  end

  assign out_data       = out_r;
  assign sts.f_need_div = f_need;
  assign sts.wsel       = w_code;
  assign sts.div_busy   = div_busy;
  assign sts.div_done   = div_done;

endmodule

>>> design/lwfc_ctrl.sv
// ----------------------------------------------------------------------------
// lwfc_ctrl
// Sequencer: steps one request through the datapath, owns the handshakes.
// ----------------------------------------------------------------------------
module lwfc_ctrl
  import lwfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_cmd,
  output logic       out_valid,
  input  logic       out_ready,
  output lwfc_ctl_t  ctl,
  input  lwfc_sts_t  sts
);

  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_UPDATE) state_nxt = ST_KEEP;
          else if (in_cmd == CMD_TRIGGER || in_cmd == CMD_END_HOLD ||
                   in_cmd == CMD_TOGGLE_NIGHT || in_cmd == CMD_DISMISS) state_nxt = ST_CMD;
        end
      end
      ST_CMD:  state_nxt = ST_IDLE;
      ST_KEEP: state_nxt = ST_FSEL;
      ST_FSEL: state_nxt = sts.f_need_div ? ST_FDIV : ST_FMUL;
      ST_FDIV: state_nxt = ST_FMUL;
      ST_FMUL: state_nxt = ST_FCOL;
      ST_FCOL: state_nxt = ST_WSEL;
      ST_WSEL: begin
        unique case (sts.wsel)
          W_DIRECT:  state_nxt = ST_WOUT;
          W_SUN:     state_nxt = ST_SPOS;
          W_DISMISS: state_nxt = ST_DFADE;
          W_NIGHT:   state_nxt = ST_NMUL;
          default:   state_nxt = ST_WDIV;
        endcase
      end
      ST_WDIV:  if (sts.div_done) state_nxt = ST_RAMPF;
      ST_DFADE: state_nxt = ST_DIM;
      ST_NMUL:  state_nxt = ST_WOUT;
      ST_RAMPF: state_nxt = ST_SPOS;
      ST_SPOS:  state_nxt = ST_SINT;
      ST_SINT:  state_nxt = ST_DIM;
      ST_DIM:   state_nxt = ST_WOUT;
      ST_WOUT:  if (slot_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      ST_CMD:  ctl.apply_cmd = 1'b1;
      ST_KEEP: ctl.keep = 1'b1;
      ST_FSEL: ctl.fsel = 1'b1;
      ST_FDIV: ctl.frac_take = 1'b1;
      ST_FMUL: ctl.fmul = 1'b1;
      ST_FCOL: ctl.fcol = 1'b1;
      ST_WSEL: begin
        ctl.wsel      = 1'b1;
        ctl.div_start = sts.wsel == W_RAMP;
      end
      ST_DFADE: ctl.dfade = 1'b1;
      ST_NMUL:  ctl.nmul = 1'b1;
      ST_RAMPF: ctl.rampf = 1'b1;
      ST_SPOS:  ctl.spos = 1'b1;
      ST_SINT:  ctl.sint = 1'b1;
      ST_DIM:   ctl.dim = 1'b1;
      ST_WOUT:  ctl.wout = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ctl.wout) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  a_out_from_wout: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_WOUT)
    else $error("result raised outside output step");

  a_div_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.div_start |-> !sts.div_busy)
    else $error("divider started while busy");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WDIV) |-> (sts.div_busy || sts.div_done))
    else $error("waiting on idle divider");

endmodule

>>> design/wakeup_light_fade_controller_unit.sv
// ----------------------------------------------------------------------------
// wakeup_light_fade_controller_unit
// Front light and RGBW wake segment fade controller, one request at a time.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data) carries a command and timestamp.
// Only an update command produces a result on the output channel
// (out_valid/out_ready/out_data); other known commands change state only,
// unknown commands are dropped.
// Config writes use cfg_valid/cfg_ready/cfg_index/cfg_data, always ready;
// write only while the unit is idle.
// A sunrise ramp recompute adds one pass of the restoring divider.
// The fixed 5 s and 1 s fade divisions use reciprocal multiplies.
// One request is in flight at a time.
// A result sits in the output register until taken; a new request is taken
// meanwhile, and the next result waits in its final step while the receiver
// stalls.
// Reset (rst_n low, synchronous) restores register defaults and fade state.
// ----------------------------------------------------------------------------
module wakeup_light_fade_controller_unit
  import lwfc_pkg::*;
#(
  parameter int STAGE_COUNT   = STAGE_COUNT_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  lwfc_ctl_t ctl;
  lwfc_sts_t sts;

  assign cfg_ready = 1'b1;

  lwfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_data.cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  lwfc_dp #(
    .STAGE_COUNT   (STAGE_COUNT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sts       (sts),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
